>>> src/bfsp_pkg.sv
// bfsp_pkg: widths, types, register codes and command/status structs
// shared by the shortest-path block; depends on nothing
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;

  localparam int VIDX_W   = 6;
  localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int DIST_W   = 32;
  localparam int NV_REG_W = 7;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef logic [VIDX_W-1:0]             vidx_t;
  typedef logic [VCNT_W-1:0]             vcnt_t;
  typedef logic [EIDX_W-1:0]             eidx_t;
  typedef logic [ECNT_W-1:0]             ecnt_t;
  typedef logic signed [DIST_W-1:0]      dist_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  localparam dist_t DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam dist_t DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_NUM_VERTICES  = 2'd0,
    REG_SOURCE_VERTEX = 2'd1,
    REG_DEST_VERTEX   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    vidx_t   from_v;
    vidx_t   to_v;
    weight_t wt;
  } edge_t;

  typedef struct packed {
    logic  valid;
    dist_t val;
  } dist_entry_t;

  typedef struct packed {
    logic  init_wr;
    vidx_t init_idx;
    logic  edge_rd;
    eidx_t edge_idx;
    logic  dist_rd;
    logic  relax_apply;
    logic  relax_check;
    logic  clr_neg;
    logic  dest_rd;
    logic  emit;
  } bfsp_cmd_t;

  typedef struct packed {
    ecnt_t edge_cnt;
    logic  out_busy;
  } bfsp_stat_t;

endpackage

>>> src/bfsp_if.sv
// bfsp_edge_if and bfsp_result_if: valid/ready channels for edge beats
// and result beats; depends on bfsp_pkg
interface bfsp_edge_if import bfsp_pkg::*; ();
  logic    valid;
  logic    ready;
  vidx_t   from_vertex;
  vidx_t   to_vertex;
  weight_t weight;
  logic    last_edge;

  modport source (output valid, output from_vertex, output to_vertex, output weight,
                  output last_edge, input ready);
  modport sink (input valid, input from_vertex, input to_vertex, input weight,
                input last_edge, output ready);
endinterface

interface bfsp_result_if import bfsp_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  unreachable;
  logic  negative_cycle;
  logic  edges_dropped;

  modport source (output valid, output distance, output unreachable,
                  output negative_cycle, output edges_dropped, input ready);
  modport sink (input valid, input distance, input unreachable,
                input negative_cycle, input edges_dropped, output ready);
endinterface

>>> src/bfsp_ctrl.sv
// bfsp_ctrl: state machine that sequences init sweep, relax passes,
// the negative-cycle pass and the result; depends on bfsp_pkg
module bfsp_ctrl import bfsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vcnt_t      n_i,
  input  logic       in_accept_i,
  input  logic       in_last_i,
  input  bfsp_stat_t stat_i,
  output bfsp_cmd_t  cmd_o,
  output logic       in_ready_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INIT = 7'b0000010,
    S_ERD  = 7'b0000100,
    S_DRD  = 7'b0001000,
    S_RLX  = 7'b0010000,
    S_DEST = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  vidx_t  idx_q, idx_d;
  ecnt_t  eidx_q, eidx_d;
  vcnt_t  pass_q, pass_d;
  vcnt_t  n_m1;
  ecnt_t  eidx_nx;
  logic   last_vtx;
  logic   check_pass;
  logic   last_visit;

  always_comb begin
    n_m1       = n_i - vcnt_t'(1);
    last_vtx   = (vcnt_t'(idx_q) == n_m1);
    check_pass = (pass_q == n_m1);
    eidx_nx    = eidx_q + ecnt_t'(1);
    last_visit = (eidx_nx == stat_i.edge_cnt);
    state_d    = state_q;
    idx_d      = idx_q;
    eidx_d     = eidx_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept_i && in_last_i) begin
          state_d = S_INIT;
          idx_d   = '0;
        end
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (last_vtx) begin
          state_d       = S_ERD;
          eidx_d        = '0;
          pass_d        = '0;
          cmd_o.clr_neg = 1'b1;
        end else begin
          idx_d = idx_q + vidx_t'(1);
        end
      end
      S_ERD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = S_DRD;
      end
      S_DRD: begin
        cmd_o.dist_rd = 1'b1;
        state_d       = S_RLX;
      end
      S_RLX: begin
        cmd_o.relax_check = check_pass;
        cmd_o.relax_apply = !check_pass;
        if (last_visit) begin
          eidx_d = '0;
          if (check_pass) begin
            state_d = S_DEST;
          end else begin
            pass_d  = pass_q + vcnt_t'(1);
            state_d = S_ERD;
          end
        end else begin
          eidx_d  = eidx_nx;
          state_d = S_ERD;
        end
      end
      S_DEST: begin
        cmd_o.dest_rd = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.init_idx = idx_q;
    cmd_o.edge_idx = eidx_q[EIDX_W-1:0];
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      eidx_q  <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      eidx_q  <= eidx_d;
      pass_q  <= pass_d;
    end
  end

endmodule

>>> src/bfsp_datapath.sv
// bfsp_datapath: edge memory, distance memory, saturating relax unit and
// result register; depends on bfsp_pkg
module bfsp_datapath import bfsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bfsp_cmd_t  cmd_i,
  output bfsp_stat_t stat_o,
  input  vcnt_t      n_i,
  input  vidx_t      source_i,
  input  vidx_t      dest_i,
  input  logic       edge_accept_i,
  input  edge_t      edge_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dist_t      distance_o,
  output logic       unreachable_o,
  output logic       negative_cycle_o,
  output logic       edges_dropped_o
);

  edge_t       edge_mem [MAX_EDGES];
  dist_entry_t dist_mem [MAX_VERTICES];

  edge_t       edge_q;
  dist_entry_t rda_q, rdb_q;
  ecnt_t       cnt_q;
  logic        ovf_q;
  logic        neg_q;
  logic        out_valid_q;
  dist_t       dist_out_q;
  logic        unr_q, negc_q, drop_q;

  logic              edge_we;
  vidx_t             rd_a_addr;
  logic [DIST_W:0]   sum;
  dist_t             cand;
  logic              better;
  logic              relax_ok;
  logic              dist_we;
  vidx_t             dist_waddr;
  dist_entry_t       dist_wdata;
  logic              dest_in;

  assign edge_we   = edge_accept_i && (cnt_q < ecnt_t'(MAX_EDGES));
  assign rd_a_addr = cmd_i.dist_rd ? edge_q.from_v : dest_i;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[cnt_q[EIDX_W-1:0]] <= edge_i;
    end
    if (cmd_i.edge_rd) begin
      edge_q <= edge_mem[cmd_i.edge_idx];
    end
  end

  always_comb begin
    sum = {rda_q.val[DIST_W-1], rda_q.val}
        + {{(DIST_W+1-WEIGHT_BITS){edge_q.wt[WEIGHT_BITS-1]}}, edge_q.wt};
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
    better   = !rdb_q.valid || ($signed(cand) < $signed(rdb_q.val));
    relax_ok = (vcnt_t'(edge_q.from_v) < n_i) && (vcnt_t'(edge_q.to_v) < n_i)
             && rda_q.valid && better;
    dist_we  = cmd_i.init_wr || (cmd_i.relax_apply && relax_ok);
    if (cmd_i.init_wr) begin
      dist_waddr       = cmd_i.init_idx;
      dist_wdata.valid = (cmd_i.init_idx == source_i);
      dist_wdata.val   = '0;
    end else begin
      dist_waddr       = edge_q.to_v;
      dist_wdata.valid = 1'b1;
      dist_wdata.val   = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (cmd_i.dist_rd || cmd_i.dest_rd) begin
      rda_q <= dist_mem[rd_a_addr];
    end
    if (cmd_i.dist_rd) begin
      rdb_q <= dist_mem[edge_q.to_v];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (edge_accept_i) begin
        if (edge_we) begin
          cnt_q <= cnt_q + ecnt_t'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clr_neg) begin
        neg_q <= 1'b0;
      end else if (cmd_i.relax_check && relax_ok) begin
        neg_q <= 1'b1;
      end
    end
  end

  assign dest_in = (vcnt_t'(dest_i) < n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      drop_q <= ovf_q;
      negc_q <= neg_q;
      if (neg_q) begin
        dist_out_q <= '0;
        unr_q      <= 1'b0;
      end else if (dest_in && rda_q.valid) begin
        dist_out_q <= rda_q.val;
        unr_q      <= 1'b0;
      end else begin
        dist_out_q <= '0;
        unr_q      <= 1'b1;
      end
    end
  end

  assign stat_o.edge_cnt = cnt_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign distance_o       = dist_out_q;
  assign unreachable_o    = unr_q;
  assign negative_cycle_o = negc_q;
  assign edges_dropped_o  = drop_q;

endmodule

>>> src/bellman_ford_shortest_path_top.sv
// Bellman-Ford shortest path over a stored edge list. Edges are taken one
// beat per cycle while the block is idle and kept in a 256-entry edge memory;
// further edges are dropped and flagged. The beat with last_edge set starts the
// run: an init sweep over the distance memory (n = num_vertices, clamped to
// 1..64), then n passes over the E stored edges (n-1 relax passes and one
// negative-cycle check), each edge visited by the read of the edge memory, the
// registered read of the distance memory and the add, saturate and compare
// before the write-back; then the destination is read and the result loaded.
// No edge beat is taken during a run. The result register lets the next
// graph load while a result waits. Registers sit on an APB port at byte
// addresses 0 (num_vertices), 4 (source_vertex) and 8 (dest_vertex).
module bellman_ford_shortest_path_top import bfsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  bfsp_edge_if.sink          edge_i,
  bfsp_result_if.source      result_o
);

  logic [NV_REG_W-1:0] nv_q;
  vidx_t               src_q;
  vidx_t               dst_q;
  vcnt_t               n_eff;
  logic                cfg_we;
  reg_idx_e            reg_idx;
  logic                in_ready;
  logic                in_accept;
  edge_t               edge_in;
  bfsp_cmd_t           cmd;
  bfsp_stat_t          stat;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q  <= NV_REG_W'(1);
      src_q <= '0;
      dst_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_NUM_VERTICES:  nv_q  <= pwdata[NV_REG_W-1:0];
        REG_SOURCE_VERTEX: src_q <= pwdata[VIDX_W-1:0];
        REG_DEST_VERTEX:   dst_q <= pwdata[VIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_VERTICES:  prdata = APB_DW'(nv_q);
      REG_SOURCE_VERTEX: prdata = APB_DW'(src_q);
      REG_DEST_VERTEX:   prdata = APB_DW'(dst_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    priority if (nv_q == '0) begin
      n_eff = vcnt_t'(1);
    end else if (32'(nv_q) > MAX_VERTICES) begin
      n_eff = vcnt_t'(MAX_VERTICES);
    end else begin
      n_eff = vcnt_t'(nv_q);
    end
  end

  assign edge_i.ready   = in_ready;
  assign in_accept      = edge_i.valid && in_ready;
  assign edge_in.from_v = edge_i.from_vertex;
  assign edge_in.to_v   = edge_i.to_vertex;
  assign edge_in.wt     = edge_i.weight;

  bfsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_accept_i (in_accept),
    .in_last_i   (edge_i.last_edge),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  bfsp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .n_i              (n_eff),
    .source_i         (src_q),
    .dest_i           (dst_q),
    .edge_accept_i    (in_accept),
    .edge_i           (edge_in),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .distance_o       (result_o.distance),
    .unreachable_o    (result_o.unreachable),
    .negative_cycle_o (result_o.negative_cycle),
    .edges_dropped_o  (result_o.edges_dropped)
  );

`ifndef SYNTH
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.unreachable && result_o.negative_cycle))
    else $error("result beat with both unreachable and negative_cycle");

  a_flag_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.unreachable || result_o.negative_cycle))
      |-> (result_o.distance == '0))
    else $error("flagged result beat with nonzero distance");

  a_last_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && edge_i.last_edge) |=> !in_ready)
    else $error("edge beat taken right after last edge");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stat.edge_cnt) <= MAX_EDGES)
    else $error("edge count beyond store depth");
`endif

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for bellman_ford_shortest_path_top; edge beats in, one
// result beat per graph checked against a shortest-path predictor, apb setup between graphs
// depends on bfsp_pkg, bfsp_edge_if, bfsp_result_if and the top level
module testbench import bfsp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1350;
  localparam int HOLD_CYCLES  = 1500;
  localparam int IDLE_GUARD   = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int NV_REG_MAX   = (1 << NV_REG_W) - 1;
  localparam logic [APB_AW-1:0] ADDR_BEYOND_REGS = APB_AW'(12);
  localparam longint DIST_HI = longint'(DIST_MAX);
  localparam longint DIST_LO = longint'(DIST_MIN);

  typedef struct packed {
    dist_t distance;
    logic  unreachable;
    logic  negative_cycle;
    logic  edges_dropped;
  } path_result_t;

  typedef struct packed {
    logic                set_cfg;
    logic [NV_REG_W-1:0] nv;
    vidx_t               src;
    vidx_t               dst;
    vidx_t               from_v;
    vidx_t               to_v;
    weight_t             wt;
    logic                last;
    logic                typed;
    dist_t               exp_dist;
    logic                unr;
    logic                neg;
  } edge_row_t;

  localparam int N_DIRECTED = 19;
  // cfg nv src dst | from to weight last | typed distance unreachable negative_cycle
  localparam edge_row_t DIRECTED [N_DIRECTED] = '{
    // reset settings, self loop of weight zero
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd0, 16'h0000, 1'b1, 1'b1, 32'sd0, 1'b0, 1'b0},
    // vertex count zero, edge outside the graph
    '{1'b1, 7'd0, 6'd0, 6'd0, 6'd63, 6'd63, 16'h8000, 1'b1, 1'b1, 32'sd0, 1'b0, 1'b0},
    // full graph, extreme weights
    '{1'b1, 7'd64, 6'd0, 6'd63, 6'd0, 6'd63, 16'h7fff, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd63, 16'h8000, 1'b1, 1'b1, -32'sd32768, 1'b0, 1'b0},
    // vertex count saturates
    '{1'b1, 7'd127, 6'd63, 6'd0, 6'd63, 6'd0, 16'h7fff, 1'b1, 1'b1, 32'sd32767, 1'b0, 1'b0},
    // negative cycle
    '{1'b1, 7'd2, 6'd0, 6'd1, 6'd0, 6'd1, 16'h0001, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd1, 6'd0, -16'sd2, 1'b1, 1'b1, 32'sd0, 1'b0, 1'b1},
    // unreachable destination
    '{1'b1, 7'd4, 6'd0, 6'd3, 6'd0, 6'd1, 16'h0005, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0},
    // destination outside the graph
    '{1'b1, 7'd4, 6'd0, 6'd40, 6'd0, 6'd1, 16'h0005, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0},
    // source outside the graph
    '{1'b1, 7'd4, 6'd50, 6'd0, 6'd0, 6'd1, 16'h0005, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0},
    // edges with an endpoint outside the graph are skipped
    '{1'b1, 7'd3, 6'd0, 6'd2, 6'd0, 6'd60, 16'h0001, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd60, 6'd2, 16'h0001, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd2, 16'h0007, 1'b1, 1'b1, 32'sd7, 1'b0, 1'b0},
    // negative cycle not reachable from the source
    '{1'b1, 7'd4, 6'd0, 6'd1, 6'd2, 6'd3, -16'sd5, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd3, 6'd2, 16'h0001, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd0, 6'd1, -16'sd3, 1'b1, 1'b1, -32'sd3, 1'b0, 1'b0},
    // alternating weight bits
    '{1'b1, 7'd3, 6'd0, 6'd2, 6'd0, 6'd1, 16'h5555, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd1, 6'd2, 16'haaaa, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, 7'd0, 6'd0, 6'd0, 6'd42, 6'd21, 16'h1234, 1'b1, 1'b0, 32'sd0, 1'b0, 1'b0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bfsp_edge_if   edge_bus ();
  bfsp_result_if result_bus ();

  bellman_ford_shortest_path_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .edge_i   (edge_bus),
    .result_o (result_bus)
  );

  edge_t               stored_edges [$];
  bit                  edges_lost = 1'b0;
  bit                  dist_ok [MAX_VERTICES];
  longint              dist_val [MAX_VERTICES];
  logic [NV_REG_W-1:0] nv_cfg = NV_REG_W'(1);
  vidx_t               src_cfg = '0;
  vidx_t               dst_cfg = '0;
  path_result_t        expected_paths [$];

  int errors = 0;
  int edges_sent = 0;
  int paths_checked = 0;
  int n_neg = 0;
  int n_unr = 0;
  int n_drop = 0;
  int cfg_writes = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  function automatic int clamp_vertices(input int nv);
    if (nv < 1) return 1;
    if (nv > MAX_VERTICES) return MAX_VERTICES;
    return nv;
  endfunction

  function automatic bit relax_pass(input int n, input bit apply);
    bit     changed;
    int     u, v;
    longint cand;
    changed = 1'b0;
    foreach (stored_edges[j]) begin
      u = stored_edges[j].from_v;
      v = stored_edges[j].to_v;
      if (u < n && v < n && dist_ok[u]) begin
        cand = dist_val[u] + longint'($signed(stored_edges[j].wt));
        if (cand > DIST_HI) cand = DIST_HI;
        if (cand < DIST_LO) cand = DIST_LO;
        if (!dist_ok[v] || cand < dist_val[v]) begin
          changed = 1'b1;
          if (apply) begin
            dist_ok[v] = 1'b1;
            dist_val[v] = cand;
          end
        end
      end
    end
    return changed;
  endfunction

  function automatic bit shortest_path_step(input edge_t e, input logic last,
                                            output path_result_t r);
    int n;
    bit neg;
    r = '0;
    if (stored_edges.size() < MAX_EDGES) stored_edges.push_back(e);
    else edges_lost = 1'b1;
    if (!last) return 1'b0;
    n = clamp_vertices(int'(nv_cfg));
    for (int i = 0; i < n; i++) begin
      dist_ok[i] = 1'b0;
      dist_val[i] = 0;
    end
    if (src_cfg < n) dist_ok[src_cfg] = 1'b1;
    for (int i = 1; i < n; i++) void'(relax_pass(n, 1'b1));
    neg = relax_pass(n, 1'b0);
    r.negative_cycle = neg;
    if (!neg) begin
      if (dst_cfg < n && dist_ok[dst_cfg]) r.distance = dist_t'(dist_val[dst_cfg]);
      else r.unreachable = 1'b1;
    end
    r.edges_dropped = edges_lost;
    stored_edges.delete();
    edges_lost = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic weight_t rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return weight_t'($urandom_range(0, 100));
    if (r < 70) return weight_t'(-int'($urandom_range(1, 20)));
    if (r < 85) return weight_t'(int'($urandom_range(0, 2000)) - 1000);
    return weight_t'($urandom);
  endfunction

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_e r);
    return APB_AW'(r) << 2;
  endfunction

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e r, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    apb_read(reg_addr(r), got);
    if (got !== want) begin
      $error("%s readback: expected %0d, got %0d", r.name(), want, got);
      errors++;
    end
  endtask

  task automatic drain_paths();
    edge_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_paths.size() != 0);
  endtask

  task automatic set_config(input int nv, input int src, input int dst);
    drain_paths();
    repeat (IDLE_GUARD) @(posedge clk_i);
    apb_write(reg_addr(REG_NUM_VERTICES), APB_DW'(nv));
    apb_write(reg_addr(REG_SOURCE_VERTEX), APB_DW'(src));
    apb_write(reg_addr(REG_DEST_VERTEX), APB_DW'(dst));
    nv_cfg  = NV_REG_W'(nv);
    src_cfg = VIDX_W'(src);
    dst_cfg = VIDX_W'(dst);
    cfg_writes++;
    check_reg(REG_NUM_VERTICES, APB_DW'(nv_cfg));
    check_reg(REG_SOURCE_VERTEX, APB_DW'(src_cfg));
    check_reg(REG_DEST_VERTEX, APB_DW'(dst_cfg));
  endtask

  task automatic send_edge(input vidx_t f, input vidx_t t, input weight_t w, input logic last,
                           input logic typed, input path_result_t typed_res);
    edge_t        e;
    path_result_t r;
    int           gap;
    gap = (!steady && $urandom_range(0, 9) < 4) ? pick_gap() : 0;
    if (gap > 0) begin
      edge_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_bus.valid       <= 1'b1;
    edge_bus.from_vertex <= f;
    edge_bus.to_vertex   <= t;
    edge_bus.weight      <= w;
    edge_bus.last_edge   <= last;
    do @(posedge clk_i); while (!edge_bus.ready);
    edges_sent++;
    e.from_v = f;
    e.to_v   = t;
    e.wt     = w;
    if (shortest_path_step(e, last, r)) begin
      if (typed) r = typed_res;
      expected_paths.push_back(r);
      n_neg  += r.negative_cycle;
      n_unr  += r.unreachable;
      n_drop += r.edges_dropped;
    end
  endtask

  task automatic random_graph(input int n_edges, input bit noise);
    int      lim;
    vidx_t   f, t;
    weight_t w;
    lim = clamp_vertices(int'(nv_cfg));
    for (int k = 0; k < n_edges; k++) begin
      if (noise || $urandom_range(0, 9) == 0) begin
        f = VIDX_W'($urandom);
        t = VIDX_W'($urandom);
        w = weight_t'($urandom);
      end else begin
        f = ($urandom_range(0, 9) < 3) ? src_cfg : VIDX_W'($urandom_range(0, lim - 1));
        t = VIDX_W'($urandom_range(0, lim - 1));
        w = rand_weight();
      end
      send_edge(f, t, w, k == n_edges - 1, 1'b0, '0);
    end
  endtask

  task automatic random_config();
    int r, nv, lim, src, dst;
    r = $urandom_range(0, 99);
    if (r < 55) nv = $urandom_range(2, 8);
    else if (r < 70) nv = $urandom_range(9, 16);
    else if (r < 80) nv = $urandom_range(17, 40);
    else if (r < 86) nv = MAX_VERTICES;
    else if (r < 90) nv = 1;
    else if (r < 93) nv = 0;
    else nv = $urandom_range(MAX_VERTICES + 1, NV_REG_MAX);
    lim = clamp_vertices(nv);
    src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
    dst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
    set_config(nv, src, dst);
  endtask

  task automatic check_path();
    path_result_t want;
    paths_checked++;
    if (expected_paths.size() == 0) begin
      $error("result beat with no graph outstanding: distance %0d", result_bus.distance);
      errors++;
    end else begin
      want = expected_paths.pop_front();
      if (result_bus.distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, result_bus.distance);
        errors++;
      end
      if (result_bus.unreachable !== want.unreachable) begin
        $error("unreachable: expected %0d, got %0d", want.unreachable, result_bus.unreachable);
        errors++;
      end
      if (result_bus.negative_cycle !== want.negative_cycle) begin
        $error("negative_cycle: expected %0d, got %0d", want.negative_cycle,
               result_bus.negative_cycle);
        errors++;
      end
      if (result_bus.edges_dropped !== want.edges_dropped) begin
        $error("edges_dropped: expected %0d, got %0d", want.edges_dropped,
               result_bus.edges_dropped);
        errors++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("timeout with %0d result beats outstanding", expected_paths.size());
    $display("** bellman_ford_shortest_path_top: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready) check_path();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    edge_row_t    row;
    path_result_t typed_res;
    int           n_edges;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    edge_bus.valid       <= 1'b0;
    edge_bus.from_vertex <= '0;
    edge_bus.to_vertex   <= '0;
    edge_bus.weight      <= '0;
    edge_bus.last_edge   <= 1'b0;
    rst_ni               <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write past the register file, must leave the reset settings alone
    apb_write(ADDR_BEYOND_REGS, '1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.set_cfg) set_config(int'(row.nv), int'(row.src), int'(row.dst));
      typed_res = '{row.exp_dist, row.unr, row.neg, 1'b0};
      send_edge(row.from_v, row.to_v, row.wt, row.last, row.typed, typed_res);
    end

    // results held back while graphs keep coming
    set_config(4, 0, 3);
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (4) random_graph(3, 1'b0);
    steady = 1'b0;
    drain_paths();

    // edge store exactly full, then overfull
    set_config(3, 0, 2);
    random_graph(MAX_EDGES, 1'b0);
    random_graph(MAX_EDGES + 2, 1'b0);
    set_config(MAX_VERTICES, 0, MAX_VERTICES - 1);
    random_graph(40, 1'b0);

    while (edges_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) random_config();
      steady = ($urandom_range(0, 6) == 0);
      n_edges = (clamp_vertices(int'(nv_cfg)) > 16) ? $urandom_range(1, 6)
                                                    : $urandom_range(1, 14);
      random_graph(n_edges, $urandom_range(0, 11) == 0);
    end
    steady = 1'b0;
    drain_paths();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d edge beats, %0d result beats, %0d register settings",
             edges_sent, paths_checked, cfg_writes);
    $display("run: %0d negative-cycle, %0d unreachable, %0d overflowed graphs",
             n_neg, n_unr, n_drop);
    if (errors == 0) begin
      $display("** bellman_ford_shortest_path_top: PASSED **");
    end else begin
      $display("** bellman_ford_shortest_path_top: FAILED **");
    end
    $finish;
  end

endmodule
